FILE: rtl/vxdp_pkg.sv
`default_nettype none

package vxdp_pkg;

  // Field widths of the stream items.
  localparam int unsigned DataW   = 8;
  localparam int unsigned PortW   = 16;
  localparam int unsigned PosW    = 7;
  localparam int unsigned StripW  = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OutTdataW = 16;

  localparam logic [PortW-1:0] VXLAN_PORT_DEFAULT = 16'd4789;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic [PosW-1:0] POS_MAX = 7'd127;

  typedef enum logic [StatusW-1:0] {
    ST_ACCEPT  = 2'd0,
    ST_NOT_UDP = 2'd1,
    ST_PORT    = 2'd2,
    ST_TRUNC   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_IPV4 = 2'd1,
    KIND_IPV6 = 2'd2
  } kind_e;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [StripW-1:0] strip_length;
  } result_t;

  function automatic kind_e kind_of(input logic [15:0] type_word);
    kind_e kind;
    kind = KIND_NONE;
    if (type_word == TYPE_IPV4) begin
      kind = KIND_IPV4;
    end else if (type_word == TYPE_IPV6) begin
      kind = KIND_IPV6;
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vxdp_parser.sv
`default_nettype none

module vxdp_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [vxdp_pkg::DataW-1:0]    data_byte_i,
  input  wire logic                          last_byte_i,
  input  wire logic                          tunnel_flag_i,
  input  wire logic [vxdp_pkg::PortW-1:0]    udp_port_i,
  output vxdp_pkg::result_t                  result_o
);
  import vxdp_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [15:0]      type_q, type_d;
  logic             vlan_q, vlan_d;
  kind_e            kind_q, kind_d;
  logic             udp_q, udp_d;
  logic [PortW-1:0] port_q, port_d;
  logic             offload_q, offload_d;

  logic             cap_type;
  logic             is_ipv4;
  logic [6:0]       l2_len, l3_len, proto_off, port_off, strip;
  logic [7:0]       len;
  status_e          status;

  always_comb begin
    offload_d = (pos_q == '0) ? tunnel_flag_i : offload_q;

    // Ethertype shift register, with the inner type after one VLAN tag.
    cap_type = (pos_q == 7'd12) || (pos_q == 7'd13) ||
               (vlan_q && ((pos_q == 7'd16) || (pos_q == 7'd17)));
    type_d   = cap_type ? {type_q[7:0], data_byte_i} : type_q;

    vlan_d = vlan_q;
    kind_d = kind_q;
    if (pos_q == 7'd13) begin
      if (type_d == TYPE_VLAN) begin
        vlan_d = 1'b1;
        kind_d = KIND_NONE;
      end else begin
        kind_d = kind_of(type_d);
      end
    end
    if (vlan_d && (pos_q == 7'd17)) begin
      kind_d = kind_of(type_d);
    end

    is_ipv4   = (kind_d == KIND_IPV4);
    l2_len    = vlan_d ? 7'd18 : 7'd14;
    l3_len    = is_ipv4 ? 7'd20 : 7'd40;
    proto_off = l2_len + (is_ipv4 ? 7'd9 : 7'd6);
    port_off  = l2_len + l3_len + 7'd2;
    strip     = l2_len + l3_len + 7'd16;

    udp_d  = udp_q;
    port_d = port_q;
    if (kind_d != KIND_NONE) begin
      if (pos_q == proto_off) begin
        udp_d = (data_byte_i == PROTO_UDP);
      end
      if ((pos_q == port_off) || (pos_q == port_off + 7'd1)) begin
        port_d = {port_q[7:0], data_byte_i};
      end
    end

    // Outcome checks in priority order.
    len = {1'b0, pos_q} + 8'd1;
    if ((len < 8'd14) || (vlan_d && (len < 8'd18))) begin
      status = ST_TRUNC;
    end else if (kind_d == KIND_NONE) begin
      status = ST_NOT_UDP;
    end else if (len <= {1'b0, proto_off}) begin
      status = ST_TRUNC;
    end else if (!udp_d) begin
      status = ST_NOT_UDP;
    end else if ((len >= ({1'b0, port_off} + 8'd2)) && (port_d != udp_port_i) &&
                 !offload_d) begin
      status = ST_PORT;
    end else if (len < {1'b0, strip}) begin
      status = ST_TRUNC;
    end else begin
      status = ST_ACCEPT;
    end

    result_o.valid        = accept_i && last_byte_i;
    result_o.status       = status;
    result_o.strip_length = (status == ST_ACCEPT) ? strip : '0;

    pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 7'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      type_q    <= '0;
      vlan_q    <= 1'b0;
      kind_q    <= KIND_NONE;
      udp_q     <= 1'b0;
      port_q    <= '0;
      offload_q <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        pos_q     <= '0;
        type_q    <= '0;
        vlan_q    <= 1'b0;
        kind_q    <= KIND_NONE;
        udp_q     <= 1'b0;
        port_q    <= '0;
        offload_q <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        type_q    <= type_d;
        vlan_q    <= vlan_d;
        kind_q    <= kind_d;
        udp_q     <= udp_d;
        port_q    <= port_d;
        offload_q <= offload_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vxdp_out_reg.sv
`default_nettype none

module vxdp_out_reg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  vxdp_pkg::result_t                    result_i,
  input  wire logic                            m_axis_tready,
  output logic                                 m_axis_tvalid,
  output logic [vxdp_pkg::OutTdataW-1:0]       m_axis_tdata
);
  import vxdp_pkg::*;

  logic              valid_q;
  status_e           status_q;
  logic [StripW-1:0] strip_q;

  // The upstream side only loads when this register is empty or draining.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (result_i.valid) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      status_q <= result_i.status;
      strip_q  <= result_i.strip_length;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(OutTdataW - StripW - StatusW){1'b0}}, strip_q, status_q};

endmodule

`default_nettype wire

FILE: rtl/vxlan_decap_header_parser_top.sv
// VXLAN decapsulation header parser.
// Packet bytes enter on the slave stream: tdata carries one byte, tlast marks
// the final byte of a packet, and tuser carries the receive-offload tunnel
// flag, which is only looked at on the first byte of a packet.
// One item leaves on the master stream for each packet, after its last byte:
// tdata bits [1:0] hold the status (accept, not UDP or unknown ethertype,
// port mismatch, truncated) and bits [8:2] the outer header length to strip.
// The parser takes one byte every cycle unless stalled; each byte only needs
// a few compares and captures against the per-packet state registers. The
// result shows on the master side in the cycle after its last byte is taken.
// A finished result waits in the output register. Bytes keep flowing while
// that register is empty or is emptied in the same cycle; while it is full
// and the receiver holds tready low, s_axis_tready is withdrawn, so a stalled
// receiver also stalls the byte stream once a result is waiting.
// The configuration channel writes the VXLAN UDP port and is always ready.
// Reset clears the parser state, empties the output register and sets the
// port to 4789.
`default_nettype none

module vxlan_decap_header_parser_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration: the VXLAN UDP destination port.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [vxdp_pkg::PortW-1:0]   cfg_data_i,
  // Packet byte stream.
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  wire logic                         s_axis_tlast,
  input  wire logic [0:0]                   s_axis_tuser,  // [0] tunnel_flag
  // Result stream.
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata   // [1:0] status,
                                                           // [8:2] strip_length
);
  import vxdp_pkg::*;

  logic [PortW-1:0] udp_port_q;
  logic             s_accept;
  result_t          result;

  // The user writes the register only when no packet is in flight; unenforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      udp_port_q <= VXLAN_PORT_DEFAULT;
    end else if (cfg_valid_i) begin
      udp_port_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Bytes are held back only when a result is waiting and cannot leave.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  vxdp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (s_accept),
    .data_byte_i   (s_axis_tdata),
    .last_byte_i   (s_axis_tlast),
    .tunnel_flag_i (s_axis_tuser[0]),
    .udp_port_i    (udp_port_q),
    .result_o      (result)
  );

  vxdp_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .result_i      (result),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // A last byte always yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tlast) |=> m_axis_tvalid)
    else $error("no result after last byte");

  // A byte that is not last never yields a result.
  a_mid_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && !s_axis_tlast) |=> !m_axis_tvalid)
    else $error("result after a non-final byte");

  // Strip length is zero unless the packet is accepted.
  a_strip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] != ST_ACCEPT)) |-> (m_axis_tdata[8:2] == 7'd0))
    else $error("strip length set on a rejected packet");

  // An accepted packet strips at least Ethernet, IPv4, UDP and VXLAN headers.
  a_strip_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] == ST_ACCEPT)) |-> (m_axis_tdata[8:2] >= 7'd50))
    else $error("strip length too short on accept");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/vxlan_decap_header_parser_checker.sv
// Watches the configuration, byte and result channels of the VXLAN header
// parser. It keeps its own copy of the per-packet parse state, works out the
// verdict of every packet when its last byte is accepted, and compares the
// results in order of arrival.
module vxlan_decap_header_parser_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic [vxdp_pkg::PortW-1:0]  cfg_data_i,
  input  wire logic                        s_tvalid_i,
  input  wire logic                        s_tready_i,
  input  wire logic [7:0]                  s_tdata_i,
  input  wire logic                        s_tlast_i,
  input  wire logic [0:0]                  s_tuser_i,
  input  wire logic                        m_tvalid_i,
  input  wire logic                        m_tready_i,
  input  wire logic [15:0]                 m_tdata_i,
  output int                               mismatches_o,
  output int                               pending_o
);
  import vxdp_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [StripW-1:0] strip;
  } verdict_t;

  verdict_t due_verdicts[$];
  int       mismatch_total = 0;

  logic [PortW-1:0] vxlan_port;
  logic [PosW-1:0]  byte_idx;
  logic [15:0]      ether_shift;
  logic             tag_seen;
  kind_e            net_kind;
  logic             l4_is_udp;
  logic [15:0]      dport_shift;
  logic             tunnel_mark;

  assign mismatches_o = mismatch_total;

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    mismatch_total++;
  endtask

  function automatic kind_e ether_kind(input logic [15:0] et);
    case (et)
      TYPE_IPV4: return KIND_IPV4;
      TYPE_IPV6: return KIND_IPV6;
      default:   return KIND_NONE;
    endcase
  endfunction

  task automatic clear_packet_state();
    byte_idx    = '0;
    ether_shift = '0;
    tag_seen    = 1'b0;
    net_kind    = KIND_NONE;
    l4_is_udp   = 1'b0;
    dport_shift = '0;
    tunnel_mark = 1'b0;
  endtask

  // Advances the parse by one byte; on the last byte the verdict is queued.
  task automatic parse_header_byte(input logic [7:0] b, input logic last,
                                   input logic tflag);
    int       pos;
    int       l2;
    int       l3;
    int       proto_at;
    int       port_at;
    int       strip;
    int       len;
    verdict_t v;
    pos = byte_idx;
    if (pos == 0) tunnel_mark = tflag;
    if (pos == 12 || pos == 13 || (tag_seen && (pos == 16 || pos == 17))) begin
      ether_shift = {ether_shift[7:0], b};
    end
    if (pos == 13) begin
      if (ether_shift == TYPE_VLAN) begin
        tag_seen = 1'b1;
        net_kind = KIND_NONE;
      end else begin
        net_kind = ether_kind(ether_shift);
      end
    end
    if (tag_seen && pos == 17) net_kind = ether_kind(ether_shift);

    l2       = tag_seen ? 18 : 14;
    l3       = (net_kind == KIND_IPV4) ? 20 : 40;
    proto_at = l2 + ((net_kind == KIND_IPV4) ? 9 : 6);
    port_at  = l2 + l3 + 2;
    strip    = l2 + l3 + 16;

    if (net_kind != KIND_NONE) begin
      if (pos == proto_at) l4_is_udp = (b == PROTO_UDP);
      if (pos == port_at || pos == port_at + 1) dport_shift = {dport_shift[7:0], b};
    end

    if (!last) begin
      if (byte_idx != POS_MAX) byte_idx = byte_idx + 1'b1;
    end else begin
      len     = pos + 1;
      v.strip = '0;
      // The first check that applies decides the outcome.
      if (len < 14 || (tag_seen && len < 18)) begin
        v.status = ST_TRUNC;
      end else if (net_kind == KIND_NONE) begin
        v.status = ST_NOT_UDP;
      end else if (len <= proto_at) begin
        v.status = ST_TRUNC;
      end else if (!l4_is_udp) begin
        v.status = ST_NOT_UDP;
      end else if (len >= port_at + 2 && dport_shift != vxlan_port && !tunnel_mark) begin
        v.status = ST_PORT;
      end else if (len < strip) begin
        v.status = ST_TRUNC;
      end else begin
        v.status = ST_ACCEPT;
        v.strip  = strip[StripW-1:0];
      end
      due_verdicts.push_back(v);
      clear_packet_state();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      vxlan_port = VXLAN_PORT_DEFAULT;
      clear_packet_state();
      due_verdicts.delete();
      pending_o <= 0;
    end else begin
      // A result leaves no earlier than the cycle after its last byte, so comparing
      // before predicting never pairs a result with its own packet early.
      if (m_tvalid_i && m_tready_i) begin
        if (due_verdicts.size() == 0) begin
          report_mismatch($sformatf("result 0x%04h arrived with none expected", m_tdata_i));
        end else begin
          want = due_verdicts.pop_front();
          if (m_tdata_i[1:0] != want.status) begin
            report_mismatch($sformatf("status %0d, expected %s",
                                      m_tdata_i[1:0], want.status.name()));
          end
          if (m_tdata_i[8:2] != want.strip) begin
            report_mismatch($sformatf("strip_length %0d, expected %0d",
                                      m_tdata_i[8:2], want.strip));
          end
          if (m_tdata_i[15:9] != '0) begin
            report_mismatch($sformatf("padding bits 0x%02h, expected zero",
                                      m_tdata_i[15:9]));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) vxlan_port = cfg_data_i;
      if (s_tvalid_i && s_tready_i) parse_header_byte(s_tdata_i, s_tlast_i, s_tuser_i[0]);
      pending_o <= due_verdicts.size();
    end
  end

endmodule

FILE: tb/sv/vxlan_decap_header_parser_top_test.sv
// Stimulus and verdict for the VXLAN header parser. Packets are built here as
// byte queues and streamed in one item per byte; the checker beside the block
// predicts and compares every result, and this module only reads back its
// mismatch count and the number of results still owed.
module vxlan_decap_header_parser_top_test;
  import vxdp_pkg::*;

  // Packet shapes. Tagged shapes carry one 802.1Q tag ahead of the inner
  // ethertype; the last one stacks a second tag, which the parser rejects.
  typedef enum int {
    FR_IPV4,
    FR_IPV6,
    FR_TAG_IPV4,
    FR_TAG_IPV6,
    FR_OTHER_TYPE,
    FR_TWO_TAGS
  } frame_e;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic [PortW-1:0]  cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic [7:0]        s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic [0:0]        s_axis_tuser  = '0;
  logic              m_axis_tready = 1'b0;
  wire logic         cfg_ready_o;
  wire logic         s_axis_tready;
  wire logic         m_axis_tvalid;
  wire logic [15:0]  m_axis_tdata;
  int                mismatch_count;
  int                results_pending;

  // Flow control knobs, in percent, and a request for one long hold-off of
  // the result stream which the receiver process counts down itself.
  int                send_idle_pct   = 0;
  int                recv_stall_pct  = 0;
  int                hold_cycles_req = 0;

  // The port the packets are aimed at, kept in step with the register.
  logic [PortW-1:0]  active_port = VXLAN_PORT_DEFAULT;
  logic [7:0]        frame_bytes[$];

  vxlan_decap_header_parser_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vxlan_decap_header_parser_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .mismatches_o (mismatch_count),
    .pending_o    (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Upper bound on the run. The slowest legal run stays far below this.
  initial begin
    #7200000;
    $display("Mismatches found");
    $finish;
  end

  // Result side. A pending hold-off request takes precedence; otherwise
  // tready is withdrawn at random according to the current stall rate.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles_req != 0) begin
        hold_left       = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Total outer header length for a shape: L2, L3, UDP and VXLAN headers.
  function automatic int outer_strip(input frame_e f);
    int l2;
    int l3;
    l2 = (f == FR_TAG_IPV4 || f == FR_TAG_IPV6 || f == FR_TWO_TAGS) ? 18 : 14;
    l3 = (f == FR_IPV4 || f == FR_TAG_IPV4) ? 20 : 40;
    return l2 + l3 + 16;
  endfunction

  // Writes a byte only where the packet is long enough to hold it.
  function automatic void set_byte(input int idx, input logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endfunction

  // Fills a packet of the given length with random bytes, then plants the
  // ethertype(s), the protocol byte and the UDP destination port at the
  // offsets that the shape implies.
  task automatic build_frame(input frame_e f, input bit udp, input logic [15:0] dport,
                             input int len);
    bit          has_tag;
    bit          is_ipv4;
    int          l2;
    int          proto_at;
    int          port_at;
    logic [15:0] inner;
    logic [7:0]  proto;
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom));
    has_tag = (f == FR_TAG_IPV4 || f == FR_TAG_IPV6 || f == FR_TWO_TAGS);
    is_ipv4 = (f == FR_IPV4 || f == FR_TAG_IPV4);
    case (f)
      FR_IPV4, FR_TAG_IPV4: inner = TYPE_IPV4;
      FR_IPV6, FR_TAG_IPV6: inner = TYPE_IPV6;
      FR_TWO_TAGS:          inner = TYPE_VLAN;
      default: begin
        do inner = 16'($urandom);
        while (inner == TYPE_IPV4 || inner == TYPE_IPV6 || inner == TYPE_VLAN);
      end
    endcase
    if (has_tag) begin
      set_byte(12, TYPE_VLAN[15:8]);
      set_byte(13, TYPE_VLAN[7:0]);
      set_byte(16, inner[15:8]);
      set_byte(17, inner[7:0]);
    end else begin
      set_byte(12, inner[15:8]);
      set_byte(13, inner[7:0]);
    end
    if (f != FR_OTHER_TYPE && f != FR_TWO_TAGS) begin
      l2       = has_tag ? 18 : 14;
      proto_at = l2 + (is_ipv4 ? 9 : 6);
      port_at  = l2 + (is_ipv4 ? 20 : 40) + 2;
      if (udp) begin
        proto = PROTO_UDP;
      end else begin
        do proto = 8'($urandom);
        while (proto == PROTO_UDP);
      end
      set_byte(proto_at, proto);
      set_byte(port_at, dport[15:8]);
      set_byte(port_at + 1, dport[7:0]);
    end
  endtask

  // Offers one byte and returns at the edge where it is taken. Any idle
  // cycles are spent before the byte is offered, never while it is up.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic tflag);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= b;
    s_axis_tlast    <= last;
    s_axis_tuser[0] <= tflag;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // The tunnel flag counts only on the first byte; later bytes carry noise
  // in tuser so that the parser is seen to ignore it.
  task automatic send_frame(input logic tunnel);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1,
                (i == 0) ? tunnel : 1'($urandom));
    end
  endtask

  // Mostly well-formed IP/UDP packets aimed at the live port, with lengths
  // around the header length; the rest are truncated, mis-typed, aimed at
  // another port or long enough to saturate the byte position.
  task automatic random_frame();
    frame_e      f;
    bit          udp;
    logic [15:0] dport;
    int          strip;
    int          len;
    int          pick;
    pick  = $urandom_range(99);
    f     = (pick < 85) ? frame_e'($urandom_range(3)) : frame_e'($urandom_range(5, 4));
    udp   = ($urandom_range(99) < 85);
    dport = ($urandom_range(99) < 70) ? active_port : 16'($urandom);
    strip = outer_strip(f);
    pick  = $urandom_range(99);
    if (pick < 45) begin
      len = strip + $urandom_range(24);
    end else if (pick < 60) begin
      len = strip;
    end else if (pick < 80) begin
      len = $urandom_range(strip - 1, 1);
    end else if (pick < 94) begin
      len = $urandom_range(40, 1);
    end else begin
      len = $urandom_range(300, 128);
    end
    build_frame(f, udp, dport, len);
    send_frame($urandom_range(99) < 30);
  endtask

  // Waits until every predicted result has been taken, then lets the
  // output stage settle.
  task automatic drain();
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // The port register is only written while the parser is between packets
  // and nothing is owed on the result side.
  task automatic write_vxlan_port(input logic [PortW-1:0] port);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= port;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    active_port = port;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets with no idling on either side, against the port value
    // that reset leaves behind. A lone byte that is also the last one is
    // truncated.
    build_frame(FR_IPV4, 1, active_port, 1);
    send_frame(1'b1);
    // Ethertype incomplete, then ethertype present but no protocol byte.
    build_frame(FR_IPV4, 1, active_port, 13);
    send_frame(1'b0);
    build_frame(FR_IPV4, 1, active_port, 14);
    send_frame(1'b0);
    // An all-zero packet gives an unknown ethertype.
    frame_bytes.delete();
    repeat (16) frame_bytes.push_back(8'h00);
    send_frame(1'b1);
    // Tag without a complete inner ethertype, a second stacked tag, and an
    // ethertype that is neither IPv4 nor IPv6.
    build_frame(FR_TAG_IPV4, 1, active_port, 16);
    send_frame(1'b0);
    build_frame(FR_TWO_TAGS, 1, active_port, 20);
    send_frame(1'b0);
    build_frame(FR_OTHER_TYPE, 1, active_port, 20);
    send_frame(1'b0);
    // IPv4 carrying something other than UDP, ending with the
    // protocol byte.
    build_frame(FR_IPV4, 0, active_port, 24);
    send_frame(1'b0);
    // Exact fit is accepted, here on a wrong port rescued by the tunnel
    // flag; one byte short is truncated.
    build_frame(FR_IPV4, 1, active_port ^ 16'h8000, 50);
    send_frame(1'b1);
    build_frame(FR_IPV4, 1, active_port, 49);
    send_frame(1'b0);
    // Wrong port without the tunnel flag is rejected as soon as both port
    // bytes are present, and truncated when only the first one is.
    build_frame(FR_IPV4, 1, active_port ^ 16'h0001, 38);
    send_frame(1'b0);
    build_frame(FR_IPV4, 1, active_port ^ 16'h0100, 37);
    send_frame(1'b0);
    // Largest strip length, and a packet long enough to saturate the byte
    // position.
    build_frame(FR_TAG_IPV6, 1, active_port, 78);
    send_frame(1'b0);
    build_frame(FR_IPV4, 1, active_port, 130);
    send_frame(1'b0);
    s_axis_tvalid <= 1'b0;

    // Random phases, each with its own port value and flow control.
    write_vxlan_port(16'h0000);
    send_idle_pct = 87;
    repeat (2) random_frame();
    s_axis_tvalid <= 1'b0;

    write_vxlan_port(16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 87;
    repeat (2) random_frame();
    s_axis_tvalid <= 1'b0;

    write_vxlan_port(16'($urandom));
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    repeat (1) random_frame();
    s_axis_tvalid <= 1'b0;

    // Back-pressure: the receiver holds off for a long stretch while short
    // packets keep coming, so the output register fills and the byte side
    // is stalled. The sender then pauses until everything has drained.
    write_vxlan_port(VXLAN_PORT_DEFAULT);
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_cycles_req = 200;
    repeat (10) begin
      build_frame(frame_e'($urandom_range(5)), 1, active_port, $urandom_range(12, 1));
      send_frame(1'($urandom));
    end
    s_axis_tvalid <= 1'b0;

    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
